// File: sv/utf8sd_pkg.sv
`timescale 1ns / 1ps

package utf8sd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned PendW = 2;

  // Substitute character '?' for malformed input.
  localparam logic [CpW-1:0] SubstChar = CpW'(63);

  localparam logic [PendW-1:0] PendIdle  = 2'd0;
  localparam logic [PendW-1:0] PendOne   = 2'd1;
  localparam logic [PendW-1:0] PendTwo   = 2'd2;
  localparam logic [PendW-1:0] PendThree = 2'd3;

  typedef struct packed {
    logic             emit;
    logic [CpW-1:0]   code_point;
    logic             replaced;
    logic [PendW-1:0] pending;
    logic [CpW-1:0]   partial;
  } step_t;

  // One decoder step: current state and one byte in, next state and result out.
  function automatic step_t decode_step(input logic [PendW-1:0] pending,
                                        input logic [CpW-1:0]   partial,
                                        input logic [ByteW-1:0] b);
    step_t          s;
    logic [CpW-1:0] gathered;
    s.emit       = 1'b0;
    s.code_point = SubstChar;
    s.replaced   = 1'b0;
    s.pending    = pending;
    s.partial    = partial;
    gathered     = {partial[CpW-7:0], b[5:0]};
    if (pending != PendIdle) begin
      if (b[7:6] != 2'b10) begin
        s.emit     = 1'b1;
        s.replaced = 1'b1;
        s.pending  = PendIdle;
        s.partial  = '0;
      end else if (pending == PendOne) begin
        s.emit       = 1'b1;
        s.code_point = gathered;
        s.pending    = PendIdle;
        s.partial    = '0;
      end else begin
        s.pending = pending - PendOne;
        s.partial = gathered;
      end
    end else if (b[7] == 1'b0) begin
      s.emit       = 1'b1;
      s.code_point = CpW'(b);
    end else if (b[7:5] == 3'b110) begin
      s.pending = PendOne;
      s.partial = CpW'(b[4:0]);
    end else if (b[7:4] == 4'b1110) begin
      s.pending = PendTwo;
      s.partial = CpW'(b[3:0]);
    end else if (b[7:3] == 5'b11110) begin
      s.pending = PendThree;
      s.partial = CpW'(b[2:0]);
    end else begin
      s.emit     = 1'b1;
      s.replaced = 1'b1;
    end
    return s;
  endfunction

endpackage

// File: sv/utf8_stream_decoder.sv
// Path: an accepted word waits in the input register until the result register is free;
// its result is then registered there. Lead and middle bytes of a sequence give no result.
// Throughput: one byte word per cycle unless out_stall_i holds a full result register;
// the input and result registers are each freed in the cycle that their contents move on.
// Reset: rst_ni clears the pending count, gathered bits and both valid flags at once;
// the decoder comes out of reset idle and ready.
`timescale 1ns / 1ps

module utf8_stream_decoder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [utf8sd_pkg::ByteW-1:0]     byte_in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [utf8sd_pkg::CpW-1:0]       code_point_o,
  output logic                             replaced_o
);

  logic                          in_vld_q, in_vld_d;
  logic [utf8sd_pkg::ByteW-1:0]  byte_q;
  logic [utf8sd_pkg::PendW-1:0]  pend_q, pend_d;
  logic [utf8sd_pkg::CpW-1:0]    part_q, part_d;
  logic                          out_vld_q, out_vld_d;
  logic [utf8sd_pkg::CpW-1:0]    cp_q;
  logic                          rep_q;
  logic                          out_free;
  logic                          process;
  utf8sd_pkg::step_t             step;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign process    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;

  assign step = utf8sd_pkg::decode_step(pend_q, part_q, byte_q);

  always_comb begin
    in_vld_d  = in_vld_q;
    pend_d    = pend_q;
    part_d    = part_q;
    out_vld_d = out_vld_q;
    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
    if (process) begin
      pend_d = step.pending;
      part_d = step.partial;
      if (step.emit) begin
        out_vld_d = 1'b1;
      end
    end
    if (!in_stall_o) begin
      in_vld_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      pend_q    <= utf8sd_pkg::PendIdle;
      part_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      pend_q    <= pend_d;
      part_q    <= part_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= byte_in_i;
    end
    if (process && step.emit) begin
      cp_q  <= step.code_point;
      rep_q <= step.replaced;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign code_point_o = cp_q;
  assign replaced_o   = rep_q;

`ifndef NO_ASSERTIONS
  // A substitute result always carries the '?' code point.
  a_subst_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && rep_q |-> cp_q == utf8sd_pkg::SubstChar)
    else $error("replaced result without substitute code point");

  // Gathered bits are cleared whenever no sequence is open.
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == utf8sd_pkg::PendIdle |-> part_q == '0)
    else $error("partial value left over in idle");

  // The input side only stalls while a held word waits on a full result register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q && out_vld_q && out_stall_i)
    else $error("input stalled without cause");

  // An ASCII byte in idle yields a result in the next cycle.
  a_ascii_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    process && pend_q == utf8sd_pkg::PendIdle && !byte_q[7] |=>
      out_vld_q && !rep_q && cp_q == utf8sd_pkg::CpW'($past(byte_q)))
    else $error("ASCII byte not passed through");
`endif

endmodule
